### rtl/wavetable_sample_generator_assert.svh
// Assertion macros for the wavetable sample generator
`ifndef WAVETABLE_SAMPLE_GENERATOR_ASSERT_SVH
`define WAVETABLE_SAMPLE_GENERATOR_ASSERT_SVH
// Implication checked at every clock edge outside reset
`define WSG_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset
`define WSG_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

### rtl/wsg_pkg.sv
// Shared constants, types and tables of the wavetable sample generator
`default_nettype none
package wsg_pkg;
    localparam int MAX_SIZE_LOG2_DEF = 16;
    localparam int SAMPLE_BITS_DEF   = 16;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int QW  = 34;  // CORDIC datapath width, Q32 plus headroom
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    localparam logic [3:0] SHAPE_ZERO   = 4'd0;
    localparam logic [3:0] SHAPE_SINE   = 4'd1;
    localparam logic [3:0] SHAPE_TRI    = 4'd2;
    localparam logic [3:0] SHAPE_SQR    = 4'd3;
    localparam logic [3:0] SHAPE_QSQR   = 4'd4;
    localparam logic [3:0] SHAPE_SAW    = 4'd5;
    localparam logic [3:0] SHAPE_RSAW   = 4'd6;
    localparam logic [3:0] SHAPE_UTRI   = 4'd7;
    localparam logic [3:0] SHAPE_USQR   = 4'd8;
    localparam logic [3:0] SHAPE_USAW   = 4'd9;
    localparam logic [3:0] SHAPE_URSAW  = 4'd10;
    localparam logic [3:0] SHAPE_USINE  = 4'd11;

    localparam logic [1:0] REG_SHAPE = 2'd0;
    localparam logic [1:0] REG_SIZE  = 2'd1;
    localparam logic [1:0] REG_PHASE = 2'd2;

    // Front-end classification carried to the back end
    typedef struct packed {
        logic        is_sine;
        logic        unipolar_sine;
        logic        flip;
        logic [31:0] angle;
        logic [33:0] direct;   // non-sine value, pre-saturation
    } wsg_item_t;

    function automatic logic [31:0] atan_turn(input int i);
        logic [31:0] t;
        case (i)
            0: t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
            3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
            6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
            9: t = 32'h00145F2F; 10: t = 32'h000A2F98; 11: t = 32'h000517CC;
            12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
            15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
            18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
            21: t = 32'h00000146; 22: t = 32'h000000A3; 23: t = 32'h00000051;
            24: t = 32'h00000029; 25: t = 32'h00000014; 26: t = 32'h0000000A;
            27: t = 32'h00000005; 28: t = 32'h00000003; 29: t = 32'h00000001;
            30: t = 32'h00000001;
            default: t = 32'h00000000;
        endcase
        return t;
    endfunction
endpackage
`default_nettype wire

### rtl/wavetable_sample_generator.sv
// Top level of the wavetable sample generator
//  channel   direction  handshake          payload
//  s_        in         s_valid/s_ready    s_sample_index[15:0]
//  m_        out        m_valid/m_ready    m_sample_value[SAMPLE_BITS-1:0]
//  cfg       in         cfg_we             cfg_index[1:0], cfg_data[15:0]
// One item per clock sustained while m_ready holds; each item passes the front-end
// register, the queue, and the CORDIC pipeline and output register of the back end.
// Synchronous active-low reset clears valid flags and registers to defaults.
// The front end keeps accepting while the queue has room; the back end
// pipeline stalls only when its output register is full and not taken.
`default_nettype none
module wavetable_sample_generator #(
    parameter int MAX_SIZE_LOG2 = wsg_pkg::MAX_SIZE_LOG2_DEF,
    parameter int SAMPLE_BITS   = wsg_pkg::SAMPLE_BITS_DEF,
    parameter int CORDIC_STAGES = wsg_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cfg_we,
    input  wire logic [1:0]              cfg_index,
    input  wire logic [15:0]             cfg_data,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [15:0]             s_sample_index,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_sample_value
);
    import wsg_pkg::*;

    logic [3:0]  shape_reg;
    logic [4:0]  size_reg;
    logic [15:0] phase_reg;
    wsg_item_t   f_item, q_item;
    logic        f_valid, f_ready, q_valid, q_ready;

    // Hold configuration; drop writes to unknown indexes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shape_reg <= SHAPE_ZERO;
            size_reg  <= 5'd10;
            phase_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_SHAPE: shape_reg <= cfg_data[3:0];
                REG_SIZE:  size_reg  <= cfg_data[4:0];
                REG_PHASE: phase_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    wsg_front #(.MAX_SIZE_LOG2(MAX_SIZE_LOG2), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .wave_shape(shape_reg), .size_log2(size_reg), .phase_fraction(phase_reg),
        .in_valid(s_valid), .in_ready(s_ready), .in_index(s_sample_index),
        .out_valid(f_valid), .out_ready(f_ready), .out_item(f_item)
    );

    wsg_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
        .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
    );

    wsg_back #(.SAMPLE_BITS(SAMPLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
        .out_valid(m_valid), .out_ready(m_ready), .out_value(m_sample_value)
    );
endmodule
`default_nettype wire

### rtl/wsg_front.sv
// Front end: phase offset, wrap, ramp, triangle and square shapes, sine angle setup
`default_nettype none
module wsg_front #(
    parameter int MAX_SIZE_LOG2 = wsg_pkg::MAX_SIZE_LOG2_DEF,
    parameter int SAMPLE_BITS   = wsg_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [3:0]        wave_shape,
    input  wire logic [4:0]        size_log2,
    input  wire logic [15:0]       phase_fraction,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [15:0]       in_index,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output wsg_pkg::wsg_item_t     out_item
);
    import wsg_pkg::*;
    localparam int F = SAMPLE_BITS - 1;
    localparam int KW = MAX_SIZE_LOG2;

    logic [4:0]        lg;
    logic [KW+16-1:0]  off_full;
    logic [KW-1:0]     mask, k;
    logic [KW-1:0]     half, quarter;
    logic signed [33:0] one, t0, t1, t2, v;
    logic [31:0]       ang;
    wsg_item_t         item_next;
    wsg_item_t         item_reg;
    logic              valid_reg;

    function automatic logic signed [33:0] ramp(input logic [KW-1:0] kk, input int m,
                                                input logic [4:0] l);
        int s;
        logic [63:0] w;
        s = F + m - int'(l);
        w = {{(64-KW){1'b0}}, kk};
        if (s >= 0) w = w << s;
        else w = w >> (-s);
        return w[33:0];
    endfunction

    always_comb begin
        lg = size_log2;
        if (lg < 5'd2) lg = 5'd2;
        if (int'(lg) > MAX_SIZE_LOG2) lg = 5'(MAX_SIZE_LOG2);
        mask = KW'(({(KW+1){1'b0}} | ((KW+1)'(1) << lg)) - (KW+1)'(1));
        off_full = (KW+16)'(({{KW{1'b0}}, phase_fraction} << lg) >> 16);
        k = (KW'(in_index) + off_full[KW-1:0]) & mask;
        half = KW'(((KW+1)'(1) << lg) >> 1);
        quarter = KW'(((KW+1)'(1) << lg) >> 2);
        one = 34'sd1 <<< F;
        t0 = ramp(k, 0, lg);
        t1 = ramp(k, 1, lg);
        t2 = ramp(k, 2, lg);
        case (wave_shape)
            SHAPE_TRI:   v = (k < half) ? t2 - one : 3 * one - t2;
            SHAPE_SQR:   v = (k < half) ? -one : one;
            SHAPE_QSQR:  v = (k < quarter) ? -one : one;
            SHAPE_SAW:   v = t1 - one;
            SHAPE_RSAW:  v = one - t1;
            SHAPE_UTRI:  v = (k < half) ? t1 : 2 * one - t1;
            SHAPE_USQR:  v = (k < half) ? 34'sd0 : one;
            SHAPE_USAW:  v = t0;
            SHAPE_URSAW: v = one - t0;
            default:     v = 34'sd0;
        endcase
        ang = 32'(({{(64-KW){1'b0}}, k} << (6'd32 - {1'b0, lg})));
        item_next.is_sine = (wave_shape == SHAPE_SINE) || (wave_shape == SHAPE_USINE);
        item_next.unipolar_sine = (wave_shape == SHAPE_USINE);
        item_next.flip = (ang >= 32'h40000000) && (ang < 32'hC0000000);
        item_next.angle = item_next.flip ? ang - 32'h80000000 : ang;
        item_next.direct = v;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end
endmodule
`default_nettype wire

### rtl/wsg_queue.sv
// Short item queue between front and back ends
`default_nettype none
module wsg_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wsg_pkg::wsg_item_t in_item,
    output logic               out_valid,
    input  wire logic          out_ready,
    output wsg_pkg::wsg_item_t out_item
);
    import wsg_pkg::*;
    wsg_item_t mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_reg, rd_reg;
    logic [QUEUE_AW:0]   cnt_reg;
    logic push, pop;

    assign in_ready  = (cnt_reg != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_item  = mem_reg[rd_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= wr_reg + 1'b1;
            if (pop) rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
        end
        if (push) mem_reg[wr_reg] <= in_item;
    end
endmodule
`default_nettype wire

### rtl/wsg_back.sv
// Back end: pipelined CORDIC sine, rounding, saturation and output register
`default_nettype none
module wsg_back #(
    parameter int SAMPLE_BITS   = wsg_pkg::SAMPLE_BITS_DEF,
    parameter int CORDIC_STAGES = wsg_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wsg_pkg::wsg_item_t     in_item,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic signed [SAMPLE_BITS-1:0] out_value
);
    import wsg_pkg::*;
    localparam int F = SAMPLE_BITS - 1;
    localparam int NS = CORDIC_STAGES + 1;
    localparam int SH = 32 - F;

    logic                 vld_reg [NS];
    logic signed [QW-1:0] x_reg [NS];
    logic signed [QW-1:0] y_reg [NS];
    logic signed [QW-1:0] z_reg [NS];
    wsg_item_t            it_reg [NS];
    logic                 adv;
    logic                 ov_reg;
    logic signed [SAMPLE_BITS-1:0] val_reg;
    logic signed [QW+1:0] q, r, sy, val;
    logic signed [QW+1:0] one;

    assign adv = !ov_reg || out_ready;
    assign in_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NS; i++) vld_reg[i] <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < NS; i++) vld_reg[i] <= vld_reg[i-1];
        end
        if (adv) begin
            it_reg[0] <= in_item;
            x_reg[0] <= QW'(64'sd2608131496);
            y_reg[0] <= '0;
            z_reg[0] <= QW'(signed'(in_item.angle));
            for (int i = 1; i < NS; i++) begin
                it_reg[i] <= it_reg[i-1];
                if (!z_reg[i-1][QW-1]) begin
                    x_reg[i] <= x_reg[i-1] - (y_reg[i-1] >>> ((i-1) % 32));
                    y_reg[i] <= y_reg[i-1] + (x_reg[i-1] >>> ((i-1) % 32));
                    z_reg[i] <= z_reg[i-1] - QW'(atan_turn((i-1) % 32));
                end else begin
                    x_reg[i] <= x_reg[i-1] + (y_reg[i-1] >>> ((i-1) % 32));
                    y_reg[i] <= y_reg[i-1] - (x_reg[i-1] >>> ((i-1) % 32));
                    z_reg[i] <= z_reg[i-1] + QW'(atan_turn((i-1) % 32));
                end
            end
        end
    end

    always_comb begin
        one = (QW+2)'(1) <<< F;
        sy = it_reg[NS-1].flip ? -(QW+2)'(y_reg[NS-1]) : (QW+2)'(y_reg[NS-1]);
        if (it_reg[NS-1].unipolar_sine) q = (QW+2)'(64'sd2147483648) + (sy >>> 1);
        else q = sy;
        r = (q + ((QW+2)'(1) <<< (SH-1))) >>> SH;
        val = it_reg[NS-1].is_sine ? r : (QW+2)'(signed'(it_reg[NS-1].direct));
        if (val > one - 1) val = one - 1;
        if (val < -one) val = -one;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (adv) begin
            ov_reg <= vld_reg[NS-1];
        end
        if (adv && vld_reg[NS-1]) val_reg <= val[SAMPLE_BITS-1:0];
    end

    assign out_valid = ov_reg;
    assign out_value = val_reg;
endmodule
`default_nettype wire

### rtl/wsg_checker.sv
// Port-level checker for the wavetable sample generator, bound to the top
`default_nettype none
`include "wavetable_sample_generator_assert.svh"
module wsg_checker #(
    parameter int SAMPLE_BITS = wsg_pkg::SAMPLE_BITS_DEF
) (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    input wire logic s_ready,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire logic [SAMPLE_BITS-1:0] m_sample_value
);
    `WSG_ASSERT_NEXT(a_m_hold, aclk, aresetn, m_valid && !m_ready, m_valid, "m_valid dropped")
    `WSG_ASSERT_NEXT(a_m_stable, aclk, aresetn, m_valid && !m_ready, $stable(m_sample_value), "m_sample_value changed")
    `WSG_ASSERT_IMPL(a_no_out_early, aclk, aresetn, !$past(aresetn), !m_valid, "m_valid right after reset")
    `WSG_ASSERT_IMPL(a_ready_free, aclk, aresetn, !m_valid, s_ready || $past(s_valid), "s_ready low without load")
endmodule
bind wavetable_sample_generator wsg_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_wsg_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_sample_value(m_sample_value)
);
`default_nettype wire
